/* design/idea_pkg.sv */
// IDEA cipher package: payload structs, constants and word arithmetic helpers.
// No dependencies; used by idea_key_sched and idea_block_cipher_unit.
package idea_pkg;

  localparam int ROUNDS_DEF = 8;
  localparam int WORD_W     = 16;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT   = 2'd2;

  typedef struct packed {
    logic [15:0] in_word1;
    logic [15:0] in_word2;
    logic [15:0] in_word3;
    logic [15:0] in_word4;
  } in_req_t;

  typedef struct packed {
    logic [15:0] out_word1;
    logic [15:0] out_word2;
    logic [15:0] out_word3;
    logic [15:0] out_word4;
  } out_res_t;

  // Low-high reduction of a 32-bit product of nonzero operands, mod 65537.
  function automatic logic [15:0] mul_reduce(input logic [31:0] q);
    logic [15:0] lo;
    logic [15:0] hi;
    lo = q[15:0];
    hi = q[31:16];
    if (lo > hi) mul_reduce = lo - hi;
    else         mul_reduce = 16'(17'(lo) + 17'd65537 - 17'(hi));
  endfunction

  // Result when one operand is the word zero (stands for 65536).
  function automatic logic [15:0] mul_zero(input logic [15:0] other);
    mul_zero = 16'(17'd65537 - 17'(other));
  endfunction

endpackage

/* design/idea_key_sched.sv */
// IDEA subkey scheduler: expands the key into the subkey memory and inverts
// for decryption. Depends on idea_pkg; owns the subkey memory.
module idea_key_sched #(
  parameter int ROUNDS = idea_pkg::ROUNDS_DEF,
  parameter int NSUB   = 6 * ROUNDS + 4,
  parameter int ADDR_W = $clog2(NSUB)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                kick,
  input  logic [127:0]        key,
  input  logic                decrypt,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [15:0]         rd_data,
  output logic                busy
);
  import idea_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXP, S_DREAD, S_DWAIT, S_INV, S_DWRITE
  } ks_state_t;

  logic [15:0] enc_mem [NSUB];
  logic [15:0] sub_mem [NSUB];

  ks_state_t   state_r;
  logic [127:0] key_r;
  logic [ADDR_W-1:0] idx_r;
  logic [2:0]  slice_r;
  logic        dec_r;
  logic [ADDR_W-1:0] src_r;
  logic [15:0] enc_q_r;
  logic [15:0] acc_r, pw_r;
  logic [4:0]  k_r;
  logic        sq_ph_r;
  logic [15:0] wdata;
  logic        wen;
  logic [ADDR_W-1:0] waddr;
  logic [31:0] prod_r;
  logic [15:0] mul_a, mul_b;
  logic        mul_zero_a, mul_zero_b;
  logic [ADDR_W-1:0] rnd_r;
  logic [2:0]  pos_r;

  // Destination round and position advance with idx_r; find source enc index.
  logic [ADDR_W-1:0] d_round, d_pos, s_round;
  always_comb begin
    d_round = rnd_r;
    d_pos   = ADDR_W'(pos_r);
    s_round = ADDR_W'(ROUNDS) - d_round;
    src_r   = '0;
    if (d_pos == 0 || d_pos == 3) src_r = ADDR_W'(s_round * 6 + d_pos);
    else if (d_pos == 1 || d_pos == 2) begin
      if (d_round == 0 || d_round == ADDR_W'(ROUNDS))
        src_r = ADDR_W'(s_round * 6 + d_pos);
      else
        src_r = ADDR_W'(s_round * 6 + (ADDR_W'(3) - d_pos));
    end else
      src_r = ADDR_W'((ADDR_W'(ROUNDS) - 1 - d_round) * 6 + d_pos);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXP) enc_mem[idx_r] <= key_r[127 - 16*slice_r -: 16];
    if (wen) sub_mem[waddr] <= wdata;
    rd_data <= sub_mem[rd_addr];
    enc_q_r <= enc_mem[src_r];
    prod_r  <= mul_a * mul_b;
  end

  // Shared square-and-multiply: phase 0 acc*=pw, phase 1 pw*=pw.
  assign mul_a = sq_ph_r ? pw_r : acc_r;
  assign mul_b = pw_r;
  assign mul_zero_a = (mul_a == '0);
  assign mul_zero_b = (mul_b == '0);
  logic [15:0] mul_res;
  logic        zero_a_r, zero_b_r;
  logic [15:0] a_q_r, b_q_r;
  logic        inv_step_r;
  always_comb begin
    if (zero_a_r)      mul_res = mul_zero(b_q_r);
    else if (zero_b_r) mul_res = mul_zero(a_q_r);
    else               mul_res = mul_reduce(prod_r);
  end

  always_comb begin
    wen   = 1'b0;
    waddr = idx_r;
    wdata = enc_q_r;
    if (state_r == S_EXP && !dec_r) begin
      wen = 1'b1;
      wdata = key_r[127 - 16*slice_r -: 16];
    end else if (state_r == S_DWRITE) begin
      wen = 1'b1;
      if (d_pos == 0 || d_pos == 3) wdata = acc_r;
      else if (d_pos == 1 || d_pos == 2) wdata = 16'(17'h10000 - 17'(enc_q_r));
      else wdata = enc_q_r;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_EXP;
      key_r      <= '0;
      dec_r      <= 1'b0;
      idx_r      <= '0;
      slice_r    <= '0;
      inv_step_r <= 1'b0;
      rnd_r      <= '0;
      pos_r      <= '0;
    end else begin
      zero_a_r <= mul_zero_a;
      zero_b_r <= mul_zero_b;
      a_q_r    <= mul_a;
      b_q_r    <= mul_b;
      if (kick) begin
        // Restart from scratch on every register write, even mid rebuild.
        state_r <= S_EXP; key_r <= key; dec_r <= decrypt;
        idx_r <= '0; slice_r <= '0;
      end else begin
        unique case (state_r)
          S_IDLE: ;
          S_EXP: begin
            slice_r <= slice_r + 3'd1;
            if (slice_r == 3'd7) key_r <= {key_r[102:0], key_r[127:103]};
            if (idx_r == ADDR_W'(NSUB - 1)) begin
              idx_r   <= '0;
              rnd_r   <= '0;
              pos_r   <= '0;
              state_r <= dec_r ? S_DREAD : S_IDLE;
            end else idx_r <= idx_r + 1'b1;
          end
          S_DREAD: state_r <= S_DWAIT;
          S_DWAIT: begin
            // Inverse only for multiplicative positions (last round has 4).
            if ((d_pos == 0 || d_pos == 3)) begin
              acc_r <= 16'd1; pw_r <= enc_q_r; k_r <= '0;
              sq_ph_r <= 1'b0; inv_step_r <= 1'b0; state_r <= S_INV;
            end else state_r <= S_DWRITE;
          end
          S_INV: begin
            // Each multiply: issue then take result next cycle.
            inv_step_r <= !inv_step_r;
            if (inv_step_r) begin
              if (!sq_ph_r) begin
                acc_r <= mul_res; sq_ph_r <= 1'b1;
              end else begin
                pw_r <= mul_res; sq_ph_r <= 1'b0;
                k_r  <= k_r + 5'd1;
                if (k_r == 5'd15) state_r <= S_DWRITE;
              end
            end
          end
          S_DWRITE: begin
            if (idx_r == ADDR_W'(NSUB - 1)) begin
              state_r <= S_IDLE; idx_r <= '0;
            end else begin
              idx_r <= idx_r + 1'b1; state_r <= S_DREAD;
              if (pos_r == 3'd5) begin
                pos_r <= '0; rnd_r <= rnd_r + 1'b1;
              end else pos_r <= pos_r + 3'd1;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_wr_idx: assert property (@(posedge clk) disable iff (!rst_n)
    wen |-> waddr < ADDR_W'(NSUB)) else $error("subkey write out of range");
  a_kick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && kick) |=> busy) else $error("kick ignored");
  a_inv_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INV |-> k_r < 5'd16) else $error("inverse overrun");
`endif
endmodule

/* design/idea_block_cipher_unit.sv */
// IDEA block cipher top level: config registers, round sequencer, output.
// Depends on idea_pkg and idea_key_sched.
//
// One request enciphers or deciphers a 64-bit block with a 128-bit key. The
// block takes a request when start is high and busy is low, and shows the
// result on out_ for one cycle with out_valid; the receiver cannot stall.
// Each round streams its six subkeys out of the subkey memory (one read per
// cycle, data arriving the cycle after its address), then does four modular
// multiplies (the last two chained) on one registered multiplier and the
// word updates. The output transform follows the last round. Busy drops in
// the same cycle as the result strobe, so the block takes a new request
// only once the previous result is out. After reset busy stays high while
// the subkeys are built, and after each configuration write it stays high
// until they are rebuilt; in decrypt mode each of the 18 multiplicative
// inverses takes 16 square/multiply steps on a shared multiplier. A write
// during a rebuild restarts it.
module idea_block_cipher_unit #(
  parameter int ROUNDS = idea_pkg::ROUNDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  idea_pkg::in_req_t                 in_req,
  output logic                              out_valid,
  output idea_pkg::out_res_t                out_res,
  input  logic                              cfg_we,
  input  logic [idea_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [idea_pkg::CFG_W-1:0]        cfg_wdata
);
  import idea_pkg::*;

  localparam int NSUB   = 6 * ROUNDS + 4;
  localparam int ADDR_W = $clog2(NSUB);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_FIN
  } core_state_t;

  core_state_t state_r;
  logic [63:0] key_hi_r, key_lo_r;
  logic        dec_r;
  logic        kick_r;
  logic        ks_busy;
  logic [ADDR_W-1:0] rd_addr_r;
  logic [15:0] sk;
  logic [15:0] z_r [6];
  logic [2:0]  zi_r;
  logic [ADDR_W-1:0] base_r;
  logic [4:0]  round_r;
  logic [15:0] x1_r, x2_r, x3_r, x4_r, kk_r;
  logic [15:0] ma_r, mb_r;
  logic [31:0] prod_r;
  logic        za_r, zb_r;
  logic [15:0] mres;

  // Hold configuration registers; restart subkey expansion on every write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0; key_lo_r <= '0; dec_r <= 1'b0; kick_r <= 1'b0;
    end else begin
      kick_r <= cfg_we && (cfg_index == REG_KEY_UPPER || cfg_index == REG_KEY_LOWER ||
                           cfg_index == REG_DECRYPT);
      if (cfg_we) begin
        priority case (cfg_index)
          REG_KEY_UPPER: key_hi_r <= cfg_wdata;
          REG_KEY_LOWER: key_lo_r <= cfg_wdata;
          REG_DECRYPT:   dec_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  idea_key_sched #(.ROUNDS(ROUNDS)) u_ks (
    .clk(clk), .rst_n(rst_n), .kick(kick_r), .key({key_hi_r, key_lo_r}),
    .decrypt(dec_r), .rd_addr(rd_addr_r), .rd_data(sk), .busy(ks_busy)
  );

  assign busy = (state_r != S_IDLE) || ks_busy || kick_r;

  // Registered multiplier, shared for all modular products.
  always_ff @(posedge clk) begin
    prod_r <= ma_r * mb_r;
    za_r   <= (ma_r == '0);
    zb_r   <= (mb_r == '0);
  end
  logic [15:0] ma_q_r, mb_q_r;
  always_ff @(posedge clk) begin ma_q_r <= ma_r; mb_q_r <= mb_r; end
  always_comb begin
    if (za_r)      mres = mul_zero(mb_q_r);
    else if (zb_r) mres = mul_zero(ma_q_r);
    else           mres = mul_reduce(prod_r);
  end

  logic last_r;
  logic [15:0] t1, t2;
  logic [1:0]  ph_r;
  assign t1 = mres;
  assign t2 = kk_r + mres;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid <= 1'b0; ph_r <= '0;
    end else begin
      out_valid <= (state_r == S_FIN);
      unique case (state_r)
        S_IDLE: if (start && !busy) begin
          x1_r <= in_req.in_word1; x2_r <= in_req.in_word2;
          x3_r <= in_req.in_word3; x4_r <= in_req.in_word4;
          base_r <= '0; round_r <= '0; rd_addr_r <= '0; zi_r <= '0;
          last_r <= (ROUNDS == 0);
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          // Stream six subkeys (data arrives the cycle after its address).
          if (zi_r != 3'd0) z_r[zi_r - 3'd1] <= sk;
          if (zi_r == 3'd6) begin
            zi_r <= '0;
            state_r <= S_MUL1; ph_r <= '0;
          end else begin
            zi_r <= zi_r + 3'd1;
            if (zi_r < 3'd5) rd_addr_r <= rd_addr_r + 1'b1;
          end
        end
        S_MUL1: begin
          // Issue x1*z0 then x4*z3; collect on following cycles.
          unique case (ph_r)
            2'd0: begin ma_r <= x1_r; mb_r <= z_r[0]; ph_r <= 2'd1; end
            2'd1: begin ma_r <= x4_r; mb_r <= z_r[3]; ph_r <= 2'd2; end
            2'd2: begin x1_r <= mres; ph_r <= 2'd3; end
            default: begin
              x4_r <= mres;
              // Output transform adds z1 to the third word and z2 to the second; other rounds the reverse.
              if (last_r) begin
                x2_r <= x2_r + z_r[2];
                x3_r <= x3_r + z_r[1];
              end else begin
                x2_r <= x2_r + z_r[1];
                x3_r <= x3_r + z_r[2];
              end
              ph_r <= '0;
              state_r <= last_r ? S_FIN : S_MUL2;
            end
          endcase
        end
        S_MUL2: begin
          if (ph_r == 2'd2) begin
            kk_r <= mres; ma_r <= z_r[5]; mb_r <= mres + (x2_r ^ x4_r);
            ph_r <= '0; state_r <= S_MUL3;
          end else begin
            ph_r <= ph_r + 2'd1;
            if (ph_r == 2'd0) begin ma_r <= z_r[4]; mb_r <= x1_r ^ x3_r; end
          end
        end
        S_MUL3: begin
          if (ph_r == 2'd1) begin
            x1_r <= x1_r ^ t1; x4_r <= x4_r ^ t2;
            x2_r <= x3_r ^ t1; x3_r <= x2_r ^ t2;
            ph_r <= '0;
            round_r <= round_r + 5'd1;
            base_r  <= base_r + ADDR_W'(6);
            rd_addr_r <= base_r + ADDR_W'(6);
            last_r <= (round_r + 5'd1 == 5'(ROUNDS));
            state_r <= S_MUL4;
          end else ph_r <= ph_r + 2'd1;
        end
        S_MUL4: state_r <= S_LOAD;
        S_FIN: begin
          out_res.out_word1 <= x1_r;
          out_res.out_word2 <= x3_r;
          out_res.out_word3 <= x2_r;
          out_res.out_word4 <= x4_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result strobe");
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> round_r <= 5'(ROUNDS)) else $error("round overrun");
  a_no_ks_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> !ks_busy) else $error("subkeys changed mid block");
`endif
endmodule
